FILE: sv/ffbs_pkg.sv
// Shared types, constants and helpers for the first-fit block suballocator.
`default_nettype none
package ffbs_pkg;

  localparam int MAX_BLOCKS = 32;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [31:0] POOL_RESET = 32'd65536;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_MERGE = 2'd2;
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_BADH = 3'd3;
  localparam logic [2:0] ST_BADSIZE = 3'd4;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_ROTATE = 2'd1;
  localparam logic [1:0] OP_PACK = 2'd2;
  localparam logic [1:0] OP_INIT = 2'd3;

  typedef struct packed {
    logic vld;
    logic free;
    logic [31:0] hnd;
    logic [31:0] off;
    logic [31:0] len;
  } entry_t;

  function automatic logic [31:0] next_h(input logic [31:0] h);
    logic [31:0] n;
    n = h + 32'd1;
    return (n == 32'd0) ? 32'd1 : n;
  endfunction

endpackage
`default_nettype wire

FILE: sv/first_fit_block_suballocator.sv
// Top level: ring of table cells and the sequencer that walks them.
// Allocate and free walk the whole cell ring once in order from the lowest
// address; coalesce walks it for the merge and again to pack the freed
// slots. A result is posted after a request's last walk. Rejected sizes,
// handle zero and unused commands skip the walk and go straight to
// posting the result. A new request is taken once the result is posted;
// one finished result can wait in the output register meanwhile. A
// pool size write on the cfg port reinitializes the table.
`default_nettype none
module first_fit_block_suballocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] req_size,
  input  wire logic [31:0] handle_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [31:0]      handle_out,
  output logic [31:0]      offset_out,
  output logic [31:0]      free_space_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  ffbs_pkg::entry_t ents [ffbs_pkg::MAX_BLOCKS];
  logic holes [ffbs_pkg::MAX_BLOCKS];
  ffbs_pkg::entry_t tail, init_ent;
  logic [1:0] cell_op;

  ffbs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .req_size(req_size), .handle_in(handle_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .handle_out(handle_out), .offset_out(offset_out),
    .free_space_out(free_space_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .head(ents[0]), .tail(tail), .init_ent(init_ent), .cell_op(cell_op)
  );

  for (genvar k = 0; k < ffbs_pkg::MAX_BLOCKS; k++) begin : g_cell
    ffbs_cell u_cell (
      .clk(clk), .rst(rst), .op(cell_op),
      .init_ent((k == 0) ? init_ent : '0),
      .up_ent((k == ffbs_pkg::MAX_BLOCKS - 1) ? tail
              : ents[(k + 1) % ffbs_pkg::MAX_BLOCKS]),
      .hole_in((k == 0) ? 1'b0 : holes[(k + ffbs_pkg::MAX_BLOCKS - 1)
                                      % ffbs_pkg::MAX_BLOCKS]),
      .ent(ents[k]),
      .hole_out(holes[k])
    );
  end

endmodule
`default_nettype wire

FILE: sv/ffbs_cell.sv
// One slot: holds an entry, shifts headward on rotate and on pack past a hole.
`default_nettype none
module ffbs_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        op,
  input  wire ffbs_pkg::entry_t  init_ent,
  input  wire ffbs_pkg::entry_t  up_ent,
  input  wire logic              hole_in,
  output ffbs_pkg::entry_t       ent,
  output logic                   hole_out
);

  assign hole_out = hole_in | ~ent.vld;

  always_ff @(posedge clk) begin
    if (rst || op == ffbs_pkg::OP_INIT) begin
      ent <= init_ent;
    end else begin
      case (op)
        ffbs_pkg::OP_ROTATE: ent <= up_ent;
        ffbs_pkg::OP_PACK: begin
          if (hole_out) begin
            ent <= up_ent;
          end
        end
        default: ent <= ent;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/ffbs_ctrl.sv
// Sequencer: walks the cell ring per request and holds the result register.
`default_nettype none
module ffbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        cmd,
  input  wire logic [31:0]       req_size,
  input  wire logic [31:0]       handle_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             status,
  output logic [31:0]            handle_out,
  output logic [31:0]            offset_out,
  output logic [31:0]            free_space_out,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [31:0]       cfg_data,
  input  wire ffbs_pkg::entry_t  head,
  output ffbs_pkg::entry_t       tail,
  output ffbs_pkg::entry_t       init_ent,
  output logic [1:0]             cell_op
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_FREE = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_PACK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [ffbs_pkg::CNT_W-1:0] LAST =
    ffbs_pkg::CNT_W'(ffbs_pkg::MAX_BLOCKS - 1);
  localparam logic [ffbs_pkg::CNT_W-1:0] FULL =
    ffbs_pkg::CNT_W'(ffbs_pkg::MAX_BLOCKS);

  logic [2:0] state, state_next;
  logic [ffbs_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [ffbs_pkg::CNT_W-1:0] count, count_next;
  logic [31:0] nh, nh_next;
  logic [31:0] fu, fu_next;
  logic found, found_next;
  logic delay, delay_next;
  ffbs_pkg::entry_t hold, hold_next;
  ffbs_pkg::entry_t pend, pend_next;
  logic [2:0] st, st_next;
  logic [31:0] ho, ho_next;
  logic [31:0] oo, oo_next;
  logic [31:0] size_r, size_r_next;
  logic [31:0] hin_r, hin_r_next;
  logic out_valid_next;
  logic in_fire, cfg_fire;
  logic [31:0] g, remh, nh1, nh2;
  ffbs_pkg::entry_t e;

  assign in_ready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign in_fire = in_valid & in_ready;
  assign cfg_fire = cfg_valid & cfg_ready;

  always_comb begin
    init_ent = '0;
    init_ent.vld = 1'b1;
    init_ent.free = 1'b1;
    init_ent.len = rst ? ffbs_pkg::POOL_RESET : cfg_data;
  end

  always_comb begin
    e = head;
    nh1 = ffbs_pkg::next_h(nh);
    nh2 = ffbs_pkg::next_h(nh1);
    g = (e.hnd == 32'd0) ? nh : e.hnd;
    remh = (e.hnd == 32'd0) ? nh1 : nh;
    state_next = state;
    cnt_next = cnt;
    count_next = count;
    nh_next = nh;
    fu_next = fu;
    found_next = found;
    delay_next = delay;
    hold_next = hold;
    pend_next = pend;
    st_next = st;
    ho_next = ho;
    oo_next = oo;
    size_r_next = size_r;
    hin_r_next = hin_r;
    out_valid_next = out_valid;
    tail = '0;
    cell_op = ffbs_pkg::OP_HOLD;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (cfg_fire) begin
          cell_op = ffbs_pkg::OP_INIT;
          count_next = ffbs_pkg::CNT_W'(1);
          nh_next = 32'd1;
          fu_next = cfg_data;
        end else if (in_fire) begin
          size_r_next = req_size;
          hin_r_next = handle_in;
          cnt_next = '0;
          found_next = 1'b0;
          delay_next = 1'b0;
          pend_next = '0;
          ho_next = '0;
          oo_next = '0;
          case (cmd)
            ffbs_pkg::CMD_ALLOC: begin
              if (req_size == 32'd0) begin
                st_next = ffbs_pkg::ST_BADSIZE;
                state_next = S_DONE;
              end else if (req_size > fu) begin
                st_next = ffbs_pkg::ST_NOSPACE;
                state_next = S_DONE;
              end else begin
                st_next = ffbs_pkg::ST_NOSPACE;
                state_next = S_ALLOC;
              end
            end
            ffbs_pkg::CMD_FREE: begin
              st_next = ffbs_pkg::ST_BADH;
              state_next = (handle_in == 32'd0) ? S_DONE : S_FREE;
            end
            ffbs_pkg::CMD_MERGE: begin
              st_next = ffbs_pkg::ST_OK;
              state_next = S_MERGE;
            end
            default: begin
              st_next = ffbs_pkg::ST_OK;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_ALLOC: begin
        cell_op = ffbs_pkg::OP_ROTATE;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) begin
          state_next = S_DONE;
        end
        tail = e;
        if (delay) begin
          tail = hold;
          hold_next = e;
        end else if (!found && e.vld && e.free && e.len >= size_r) begin
          found_next = 1'b1;
          if (e.len != size_r) begin
            if (count == FULL) begin
              st_next = ffbs_pkg::ST_FULL;
            end else begin
              tail.len = size_r;
              tail.free = 1'b0;
              tail.hnd = g;
              hold_next.vld = 1'b1;
              hold_next.free = 1'b1;
              hold_next.hnd = remh;
              hold_next.off = e.off + size_r;
              hold_next.len = e.len - size_r;
              nh_next = (e.hnd == 32'd0) ? nh2 : nh1;
              delay_next = 1'b1;
              count_next = count + 1'b1;
              fu_next = fu - size_r;
              st_next = ffbs_pkg::ST_OK;
              ho_next = g;
              oo_next = e.off;
            end
          end else begin
            tail.free = 1'b0;
            tail.hnd = g;
            nh_next = (e.hnd == 32'd0) ? nh1 : nh;
            fu_next = fu - size_r;
            st_next = ffbs_pkg::ST_OK;
            ho_next = g;
            oo_next = e.off;
          end
        end
      end
      S_FREE: begin
        cell_op = ffbs_pkg::OP_ROTATE;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) begin
          state_next = S_DONE;
        end
        tail = e;
        if (!found && e.vld && e.hnd == hin_r) begin
          found_next = 1'b1;
          if (!e.free) begin
            tail.free = 1'b1;
            fu_next = fu + e.len;
            st_next = ffbs_pkg::ST_OK;
          end
        end
      end
      S_MERGE: begin
        cell_op = ffbs_pkg::OP_ROTATE;
        cnt_next = cnt + 1'b1;
        if (cnt == FULL) begin
          tail = pend;
          cnt_next = '0;
          state_next = S_PACK;
        end else if (e.vld) begin
          if (pend.vld && pend.free && e.free) begin
            pend_next.len = pend.len + e.len;
            count_next = count - 1'b1;
          end else begin
            tail = pend;
            pend_next = e;
          end
        end
      end
      S_PACK: begin
        cell_op = ffbs_pkg::OP_PACK;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      count <= ffbs_pkg::CNT_W'(1);
      nh <= 32'd1;
      fu <= ffbs_pkg::POOL_RESET;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      count <= count_next;
      nh <= nh_next;
      fu <= fu_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    found <= found_next;
    delay <= delay_next;
    hold <= hold_next;
    pend <= pend_next;
    st <= st_next;
    ho <= ho_next;
    oo <= oo_next;
    size_r <= size_r_next;
    hin_r <= hin_r_next;
    if (state == S_DONE && (!out_valid || out_ready)) begin
      status <= st;
      handle_out <= ho;
      offset_out <= oo;
      free_space_out <= fu;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= FULL) else $error("entry count out of range");
  a_handle_nonzero: assert property (@(posedge clk) disable iff (rst)
    nh != 32'd0) else $error("next handle is zero");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready) else $error("ready right after accept");
`endif

endmodule
`default_nettype wire
